[hdl/obot_pkg.sv]
package obot_pkg;

	// coordinate width of every input field
	localparam int CB = 16;
	// corner and axis width
	localparam int AW = CB + 1;
	// reference minus corner
	localparam int DW = CB + 2;
	// one product term of a projection
	localparam int TW = AW + DW;
	// projection (sum of two terms)
	localparam int PW = TW + 1;
	// interval distance and overlap
	localparam int XW = PW + 1;
	// centre difference and its dot product with an axis
	localparam int CW = CB + 1;
	localparam int GW = 2 * CW + 1;
	// flipped axis: negating the most negative axis needs one more bit
	localparam int FW = AW + 1;
	// push output width and full product width
	localparam int OW = 55;
	localparam int MW = XW + FW;
	localparam int QW = (MW > OW) ? MW : OW;

	typedef logic signed [AW-1:0] axis_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [TW-1:0] term_t;
	typedef logic signed [PW-1:0] proj_t;
	typedef logic signed [XW-1:0] dist_t;
	typedef logic signed [CW-1:0] cdif_t;
	typedef logic signed [GW-1:0] gdot_t;
	typedef logic signed [FW-1:0] flip_t;

endpackage

[hdl/oriented_box_overlap_translation.sv]
// channel  | direction | handshake            | word
// in       | input     | in_valid / in_ready  | two boxes: centre, tl and tr offsets each
// out      | output    | out_valid / out_ready| hit, push_x, push_y
//
// An accepted input word passes through every register stage before its output word is valid;
// one word enters per cycle while the output word is not held. Depth is set by the eight register stages:
// corners/axes, corner differences, products, projections, min/max,
// distances, axis select with flip, and the final overlap times axis multiply.
// arst_n clears the valid bits of all stages; payload registers are not reset.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module oriented_box_overlap_translation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [obot_pkg::CB-1:0] a_centre_x,
	input  logic signed [obot_pkg::CB-1:0] a_centre_y,
	input  logic signed [obot_pkg::CB-1:0] a_tl_x,
	input  logic signed [obot_pkg::CB-1:0] a_tl_y,
	input  logic signed [obot_pkg::CB-1:0] a_tr_x,
	input  logic signed [obot_pkg::CB-1:0] a_tr_y,
	input  logic signed [obot_pkg::CB-1:0] b_centre_x,
	input  logic signed [obot_pkg::CB-1:0] b_centre_y,
	input  logic signed [obot_pkg::CB-1:0] b_tl_x,
	input  logic signed [obot_pkg::CB-1:0] b_tl_y,
	input  logic signed [obot_pkg::CB-1:0] b_tr_x,
	input  logic signed [obot_pkg::CB-1:0] b_tr_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic signed [obot_pkg::OW-1:0] push_x,
	output logic signed [obot_pkg::OW-1:0] push_y
);

	localparam int AW = obot_pkg::AW;
	localparam int DW = obot_pkg::DW;
	localparam int TW = obot_pkg::TW;
	localparam int PW = obot_pkg::PW;
	localparam int XW = obot_pkg::XW;
	localparam int CW = obot_pkg::CW;
	localparam int GW = obot_pkg::GW;
	localparam int FW = obot_pkg::FW;
	localparam int OW = obot_pkg::OW;
	localparam int QW = obot_pkg::QW;

	// advance the whole pipe unless the output word is held
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	logic [7:0] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[6:0], in_valid};
		end
	end

	// stage 1: corners of both boxes (A in 0..3, B in 4..7), four axes, centre difference
	obot_pkg::axis_t cx_s1 [8];
	obot_pkg::axis_t cy_s1 [8];
	obot_pkg::axis_t ax_s1 [4];
	obot_pkg::axis_t ay_s1 [4];
	obot_pkg::cdif_t gx_s1, gy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1[0] <= AW'(a_centre_x) + AW'(a_tl_x);
			cy_s1[0] <= AW'(a_centre_y) + AW'(a_tl_y);
			cx_s1[1] <= AW'(a_centre_x) + AW'(a_tr_x);
			cy_s1[1] <= AW'(a_centre_y) + AW'(a_tr_y);
			cx_s1[2] <= AW'(a_centre_x) - AW'(a_tl_x);
			cy_s1[2] <= AW'(a_centre_y) - AW'(a_tl_y);
			cx_s1[3] <= AW'(a_centre_x) - AW'(a_tr_x);
			cy_s1[3] <= AW'(a_centre_y) - AW'(a_tr_y);
			cx_s1[4] <= AW'(b_centre_x) + AW'(b_tl_x);
			cy_s1[4] <= AW'(b_centre_y) + AW'(b_tl_y);
			cx_s1[5] <= AW'(b_centre_x) + AW'(b_tr_x);
			cy_s1[5] <= AW'(b_centre_y) + AW'(b_tr_y);
			cx_s1[6] <= AW'(b_centre_x) - AW'(b_tl_x);
			cy_s1[6] <= AW'(b_centre_y) - AW'(b_tl_y);
			cx_s1[7] <= AW'(b_centre_x) - AW'(b_tr_x);
			cy_s1[7] <= AW'(b_centre_y) - AW'(b_tr_y);
			ax_s1[0] <= AW'(a_tr_x) - AW'(a_tl_x);
			ay_s1[0] <= AW'(a_tr_y) - AW'(a_tl_y);
			ax_s1[1] <= AW'(a_tr_x) + AW'(a_tl_x);
			ay_s1[1] <= AW'(a_tr_y) + AW'(a_tl_y);
			ax_s1[2] <= AW'(b_tr_x) - AW'(b_tl_x);
			ay_s1[2] <= AW'(b_tr_y) - AW'(b_tl_y);
			ax_s1[3] <= AW'(b_tr_x) + AW'(b_tl_x);
			ay_s1[3] <= AW'(b_tr_y) + AW'(b_tl_y);
			gx_s1 <= CW'(a_centre_x) - CW'(b_centre_x);
			gy_s1 <= CW'(a_centre_y) - CW'(b_centre_y);
		end
	end

	// stage 2: offsets from the reference corner (corner i of A for axis i)
	obot_pkg::diff_t dx_s2 [4][8];
	obot_pkg::diff_t dy_s2 [4][8];
	obot_pkg::axis_t ax_s2 [4];
	obot_pkg::axis_t ay_s2 [4];
	obot_pkg::cdif_t gx_s2, gy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int k = 0; k < 8; k++) begin
					dx_s2[i][k] <= DW'(cx_s1[i]) - DW'(cx_s1[k]);
					dy_s2[i][k] <= DW'(cy_s1[i]) - DW'(cy_s1[k]);
				end
				ax_s2[i] <= ax_s1[i];
				ay_s2[i] <= ay_s1[i];
			end
			gx_s2 <= gx_s1;
			gy_s2 <= gy_s1;
		end
	end

	// stage 3: product terms of every projection and of the direction test
	obot_pkg::term_t tx_s3 [4][8];
	obot_pkg::term_t ty_s3 [4][8];
	logic signed [2*CW-1:0] hx_s3 [4];
	logic signed [2*CW-1:0] hy_s3 [4];
	obot_pkg::axis_t ax_s3 [4];
	obot_pkg::axis_t ay_s3 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int k = 0; k < 8; k++) begin
					tx_s3[i][k] <= TW'(ax_s2[i]) * TW'(dx_s2[i][k]);
					ty_s3[i][k] <= TW'(ay_s2[i]) * TW'(dy_s2[i][k]);
				end
				hx_s3[i] <= (2*CW)'(gx_s2) * (2*CW)'(ax_s2[i]);
				hy_s3[i] <= (2*CW)'(gy_s2) * (2*CW)'(ay_s2[i]);
				ax_s3[i] <= ax_s2[i];
				ay_s3[i] <= ay_s2[i];
			end
		end
	end

	// stage 4: projections and direction dot products
	obot_pkg::proj_t p_s4 [4][8];
	obot_pkg::gdot_t g_s4 [4];
	obot_pkg::axis_t ax_s4 [4];
	obot_pkg::axis_t ay_s4 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int k = 0; k < 8; k++) begin
					p_s4[i][k] <= PW'(tx_s3[i][k]) + PW'(ty_s3[i][k]);
				end
				g_s4[i] <= GW'(hx_s3[i]) + GW'(hy_s3[i]);
				ax_s4[i] <= ax_s3[i];
				ay_s4[i] <= ay_s3[i];
			end
		end
	end

	// stage 5: interval ends of each box on each axis
	obot_pkg::proj_t mna_c [4], mxa_c [4], mnb_c [4], mxb_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mna_c[i] = p_s4[i][0];
			mxa_c[i] = p_s4[i][0];
			mnb_c[i] = p_s4[i][4];
			mxb_c[i] = p_s4[i][4];
			for (int k = 1; k < 4; k++) begin
				if (p_s4[i][k] < mna_c[i]) mna_c[i] = p_s4[i][k];
				if (p_s4[i][k] > mxa_c[i]) mxa_c[i] = p_s4[i][k];
				if (p_s4[i][k+4] < mnb_c[i]) mnb_c[i] = p_s4[i][k+4];
				if (p_s4[i][k+4] > mxb_c[i]) mxb_c[i] = p_s4[i][k+4];
			end
		end
	end

	obot_pkg::proj_t mna_s5 [4], mxa_s5 [4], mnb_s5 [4], mxb_s5 [4];
	logic [3:0] neg_s5;
	obot_pkg::axis_t ax_s5 [4];
	obot_pkg::axis_t ay_s5 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mna_s5[i] <= mna_c[i];
				mxa_s5[i] <= mxa_c[i];
				mnb_s5[i] <= mnb_c[i];
				mxb_s5[i] <= mxb_c[i];
				neg_s5[i] <= g_s4[i][GW-1];
				ax_s5[i] <= ax_s4[i];
				ay_s5[i] <= ay_s4[i];
			end
		end
	end

	// stage 6: interval distance, overlap and the separation flag
	obot_pkg::dist_t dist_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (mna_s5[i] < mnb_s5[i]) begin
				dist_c[i] = XW'(mnb_s5[i]) - XW'(mxa_s5[i]);
			end else begin
				dist_c[i] = XW'(mna_s5[i]) - XW'(mxb_s5[i]);
			end
		end
	end

	obot_pkg::dist_t ov_s6 [4];
	logic sep_s6;
	logic [3:0] neg_s6;
	obot_pkg::axis_t ax_s6 [4];
	obot_pkg::axis_t ay_s6 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			sep_s6 <= (dist_c[0] > 0) || (dist_c[1] > 0) || (dist_c[2] > 0)
				|| (dist_c[3] > 0);
			for (int i = 0; i < 4; i++) begin
				ov_s6[i] <= -dist_c[i];
				ax_s6[i] <= ax_s5[i];
				ay_s6[i] <= ay_s5[i];
			end
			neg_s6 <= neg_s5;
		end
	end

	// stage 7: smallest overlap, first axis wins ties; flip it toward the first box
	obot_pkg::dist_t best_c;
	logic [1:0] sel_c;

	always_comb begin
		best_c = ov_s6[0];
		sel_c = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (ov_s6[i] < best_c) begin
				best_c = ov_s6[i];
				sel_c = 2'(i);
			end
		end
	end

	obot_pkg::dist_t best_s7;
	obot_pkg::flip_t fx_s7, fy_s7;
	logic sep_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			best_s7 <= best_c;
			sep_s7 <= sep_s6;
			if (neg_s6[sel_c]) begin
				fx_s7 <= -FW'(ax_s6[sel_c]);
				fy_s7 <= -FW'(ay_s6[sel_c]);
			end else begin
				fx_s7 <= FW'(ax_s6[sel_c]);
				fy_s7 <= FW'(ay_s6[sel_c]);
			end
		end
	end

	// stage 8: overlap times axis; drop to zero when separated
	logic signed [QW-1:0] qx_c, qy_c;
	assign qx_c = QW'(best_s7) * QW'(fx_s7);
	assign qy_c = QW'(best_s7) * QW'(fy_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			if (sep_s7) begin
				hit <= 1'b0;
				push_x <= '0;
				push_y <= '0;
			end else begin
				hit <= (best_s7 != 0) && ((fx_s7 != 0) || (fy_s7 != 0));
				push_x <= qx_c[OW-1:0];
				push_y <= qy_c[OW-1:0];
			end
		end
	end

	assign out_valid = v_q[7];

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (push_x != 0) || (push_y != 0))
		else $error("hit with zero push");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (push_x == 0) && (push_y == 0))
		else $error("miss with nonzero push");

	a_hold_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(push_x) && $stable(push_y))
		else $error("held output word changed");

endmodule
